// File: sv/rv32im_instruction_step_unit_macros.svh
// assertion macros for the rv32im instruction step unit
`ifndef RV32IM_INSTRUCTION_STEP_UNIT_MACROS_SVH
`define RV32IM_INSTRUCTION_STEP_UNIT_MACROS_SVH

// same-cycle implication
`define RVSTEP_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rvstep assertion failed");

// next-cycle implication
`define RVSTEP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rvstep assertion failed");

`endif

// File: sv/rvstep_pkg.sv
// shared types and constants of the rv32im instruction step unit
package rvstep_pkg;

    localparam int MEM_WORDS_DEF = 16384;
    localparam int STACK_GAP_DEF = 16;
    localparam int NUM_REGS      = 32;
    localparam int XLEN          = 32;
    localparam int LOAD_ADDR_W   = 14;
    localparam int PC_OUT_W      = 14;
    localparam int PROG_WORDS_W  = 15;
    localparam int REG_IDX_W     = 5;
    localparam int PADDR_W       = 3;

    localparam logic [REG_IDX_W-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_IDX_W-1:0] REG_SP   = 5'd2;

    // register index taken from the byte address
    localparam logic REG_PROGRAM_WORDS = 1'b0;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;

    localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

    typedef enum logic [1:0] {
        HALT_NONE     = 2'd0,
        HALT_ECALL    = 2'd1,
        HALT_ILLEGAL  = 2'd2,
        HALT_PC_RANGE = 2'd3
    } halt_t;

    typedef enum logic [2:0] {
        KIND_SIMPLE = 3'd0,
        KIND_MUL    = 3'd1,
        KIND_DIV    = 3'd2,
        KIND_LOAD   = 3'd3,
        KIND_STORE  = 3'd4
    } kind_t;

    typedef struct packed {
        logic in_ready;
        logic latch_ins;
        logic exec;
        logic mul_fix;
        logic div_step;
        logic div_fix;
        logic mem_rd;
        logic ld_cap;
        logic ld_fix;
        logic st_wr;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  in_valid;
        logic  can_run;
        logic  last_byte;
        logic  div_last;
        logic  out_free;
        kind_t kind;
    } dp_stat_t;

endpackage

// File: sv/rvstep_ifs.sv
// item channel interfaces of the rv32im instruction step unit
interface rvstep_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic [rvstep_pkg::LOAD_ADDR_W-1:0]   load_address;
    logic [rvstep_pkg::XLEN-1:0]          load_data;

    modport source (output valid, command, load_address, load_data, input ready);
    modport sink   (input valid, command, load_address, load_data, output ready);
endinterface

interface rvstep_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [rvstep_pkg::XLEN-1:0]          executed_word;
    logic [rvstep_pkg::PC_OUT_W-1:0]      next_pc;
    logic                                 reg_written;
    logic [rvstep_pkg::REG_IDX_W-1:0]     dest_index;
    logic [rvstep_pkg::XLEN-1:0]          dest_value;
    logic [1:0]                           halt_status;

    modport source (output valid, executed_word, next_pc, reg_written, dest_index,
                    dest_value, halt_status, input ready);
    modport sink   (input valid, executed_word, next_pc, reg_written, dest_index,
                    dest_value, halt_status, output ready);
endinterface

// File: sv/rvstep_ctrl.sv
// controller state machine of the rv32im instruction step unit
module rvstep_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rvstep_pkg::dp_stat_t  stat,
    output rvstep_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECODE = 11'b000_0000_0010,
        S_EXEC   = 11'b000_0000_0100,
        S_MULFIX = 11'b000_0000_1000,
        S_DIV    = 11'b000_0001_0000,
        S_DIVFIX = 11'b000_0010_0000,
        S_MRD    = 11'b000_0100_0000,
        S_LDCAP  = 11'b000_1000_0000,
        S_LDFIX  = 11'b001_0000_0000,
        S_STWR   = 11'b010_0000_0000,
        S_FINISH = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = stat.can_run ? S_DECODE : S_FINISH;
                end
            end
            S_DECODE:
            begin
                cmd.latch_ins = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (stat.kind)
                    rvstep_pkg::KIND_MUL:   state_next = S_MULFIX;
                    rvstep_pkg::KIND_DIV:   state_next = S_DIV;
                    rvstep_pkg::KIND_LOAD:  state_next = S_MRD;
                    rvstep_pkg::KIND_STORE: state_next = S_MRD;
                    default:                state_next = S_FINISH;
                endcase
            end
            S_MULFIX:
            begin
                cmd.mul_fix = 1'b1;
                state_next  = S_FINISH;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DIVFIX;
                end
            end
            S_DIVFIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = S_FINISH;
            end
            S_MRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = (stat.kind == rvstep_pkg::KIND_LOAD) ? S_LDCAP : S_STWR;
            end
            S_LDCAP:
            begin
                cmd.ld_cap = 1'b1;
                state_next = stat.last_byte ? S_LDFIX : S_MRD;
            end
            S_LDFIX:
            begin
                cmd.ld_fix = 1'b1;
                state_next = S_FINISH;
            end
            S_STWR:
            begin
                cmd.st_wr  = 1'b1;
                state_next = stat.last_byte ? S_FINISH : S_MRD;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/rvstep_dp.sv
// datapath of the rv32im instruction step unit: memory, register file, alu, mul, div
module rvstep_dp #(
    parameter int MEM_WORDS = rvstep_pkg::MEM_WORDS_DEF,
    parameter int STACK_GAP = rvstep_pkg::STACK_GAP_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rvstep_pkg::ctrl_cmd_t                  cmd,
    output rvstep_pkg::dp_stat_t                   stat,
    input  logic                                   in_valid,
    input  logic                                   command,
    input  logic [rvstep_pkg::LOAD_ADDR_W-1:0]     load_address,
    input  logic [rvstep_pkg::XLEN-1:0]            load_data,
    input  logic [rvstep_pkg::PROG_WORDS_W-1:0]    program_words,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [rvstep_pkg::XLEN-1:0]            executed_word,
    output logic [rvstep_pkg::PC_OUT_W-1:0]        next_pc,
    output logic                                   reg_written,
    output logic [rvstep_pkg::REG_IDX_W-1:0]       dest_index,
    output logic [rvstep_pkg::XLEN-1:0]            dest_value,
    output logic [1:0]                             halt_status
);

    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam int BYTE_W = ADDR_W + 2;
    localparam logic [31:0] STACK_TOP = 32'(4 * MEM_WORDS - STACK_GAP);

    // architectural state
    logic [ADDR_W-1:0]         pc_reg;
    rvstep_pkg::halt_t         halt_reg;
    logic [31:0]               mem [MEM_WORDS];
    logic [31:0]               mem_q;
    logic [31:0]               rf [rvstep_pkg::NUM_REGS];
    logic [rvstep_pkg::NUM_REGS-1:0] rf_vld_reg;
    logic [31:0]               rs1_q;
    logic [31:0]               rs2_q;

    // per-item working registers
    logic [31:0]               ins_reg;
    logic [31:0]               exw_reg;
    logic [31:0]               res_reg;
    logic                      wr_reg;
    logic [ADDR_W-1:0]         npc_reg;
    rvstep_pkg::halt_t         st_reg;
    logic [31:0]               addr_reg;
    logic [1:0]                k_reg;
    logic [1:0]                lane_reg;
    logic [ADDR_W-1:0]         waddr_reg;
    logic [31:0]               acc_reg;
    logic [63:0]               prod_reg;
    logic [31:0]               drem_reg;
    logic [31:0]               dquo_reg;
    logic [31:0]               dvs_reg;
    logic [4:0]                dcnt_reg;

    // output register
    logic                      out_valid_reg;
    logic [31:0]               out_exw_reg;
    logic [rvstep_pkg::PC_OUT_W-1:0] out_npc_reg;
    logic                      out_wr_reg;
    logic [4:0]                out_rd_reg;
    logic [31:0]               out_val_reg;
    rvstep_pkg::halt_t         out_halt_reg;

    logic                      in_fire;
    logic                      can_run;

    // decode
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] pc32;
    logic [31:0] pc_byte;
    logic [31:0] pc_inc32;
    logic [31:0] link_v;
    logic [ADDR_W-1:0] seq_pc;
    logic [31:0] br_sum;
    logic [31:0] jal_sum;
    logic [31:0] jalr_sum;
    logic [31:0] op_b;
    logic [4:0]  shamt;
    logic        alt;
    logic        is_op;
    logic        alu_ok;
    logic [31:0] alu_res;
    logic        take;

    logic        ex_ok;
    logic        ex_wr;
    logic [31:0] ex_res;
    logic [ADDR_W-1:0] ex_npc;
    rvstep_pkg::halt_t ex_status;
    rvstep_pkg::kind_t ex_kind;

    // memory ports
    logic        mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0] mem_wdata;
    logic        mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [31:0] baddr;
    logic [1:0]  n_m1;
    logic [31:0] st_word;
    logic [7:0]  st_byte;

    logic [63:0] prod_c;
    logic [31:0] mul_hi;
    logic [31:0] corr_a;
    logic [31:0] corr_b;
    logic        a_neg;
    logic        b_neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [32:0] div_rr;
    logic [32:0] div_diff;
    logic [31:0] quo_fix;
    logic [31:0] rem_fix;
    logic        wr_eff;

    assign in_fire = in_valid && cmd.in_ready;
    assign can_run = command && (halt_reg == rvstep_pkg::HALT_NONE)
                     && (32'(pc_reg) < 32'(program_words));

    assign opc   = ins_reg[6:0];
    assign rd    = ins_reg[11:7];
    assign f3    = ins_reg[14:12];
    assign f7    = ins_reg[31:25];
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign imm_b = {{19{ins_reg[31]}}, ins_reg[31], ins_reg[7], ins_reg[30:25],
                    ins_reg[11:8], 1'b0};
    assign imm_j = {{11{ins_reg[31]}}, ins_reg[31], ins_reg[19:12], ins_reg[20],
                    ins_reg[30:21], 1'b0};
    assign imm_u = ins_reg & rvstep_pkg::UPPER_MASK;

    assign pc32     = 32'(pc_reg);
    assign pc_byte  = pc32 << 2;
    assign pc_inc32 = pc32 + 32'd1;
    assign link_v   = pc_inc32 << 2;
    assign seq_pc   = pc_reg + ADDR_W'(1);
    assign br_sum   = pc_byte + imm_b;
    assign jal_sum  = pc_byte + imm_j;
    assign jalr_sum = rs1_q + imm_i;

    assign is_op = (opc == rvstep_pkg::OPC_OP);
    assign op_b  = is_op ? rs2_q : imm_i;
    assign shamt = op_b[4:0];
    assign alt   = (f7 == rvstep_pkg::F7_ALT);

    always_comb
    begin
        if (is_op)
        begin
            alu_ok = (f7 == rvstep_pkg::F7_BASE) || (alt && (f3 inside {3'd0, 3'd5}));
        end
        else
        begin
            alu_ok = !((f3 == 3'd1) && (f7 != rvstep_pkg::F7_BASE))
                     && !((f3 == 3'd5) && (f7 != rvstep_pkg::F7_BASE) && !alt);
        end
        case (f3)
            3'd0:    alu_res = (is_op && alt) ? (rs1_q - op_b) : (rs1_q + op_b);
            3'd1:    alu_res = rs1_q << shamt;
            3'd2:    alu_res = 32'($signed(rs1_q) < $signed(op_b));
            3'd3:    alu_res = 32'(rs1_q < op_b);
            3'd4:    alu_res = rs1_q ^ op_b;
            3'd5:    alu_res = alt ? 32'($signed(rs1_q) >>> shamt) : (rs1_q >> shamt);
            3'd6:    alu_res = rs1_q | op_b;
            default: alu_res = rs1_q & op_b;
        endcase
        case (f3)
            3'd0:    take = (rs1_q == rs2_q);
            3'd1:    take = (rs1_q != rs2_q);
            3'd4:    take = ($signed(rs1_q) < $signed(rs2_q));
            3'd5:    take = ($signed(rs1_q) >= $signed(rs2_q));
            3'd6:    take = (rs1_q < rs2_q);
            default: take = (rs1_q >= rs2_q);
        endcase
    end

    always_comb
    begin
        ex_ok     = 1'b0;
        ex_wr     = 1'b0;
        ex_res    = '0;
        ex_npc    = seq_pc;
        ex_status = rvstep_pkg::HALT_NONE;
        ex_kind   = rvstep_pkg::KIND_SIMPLE;
        case (opc)
            rvstep_pkg::OPC_LOAD:
            begin
                ex_ok   = f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5};
                ex_wr   = 1'b1;
                ex_kind = rvstep_pkg::KIND_LOAD;
            end
            rvstep_pkg::OPC_OPIMM:
            begin
                ex_ok  = alu_ok;
                ex_wr  = 1'b1;
                ex_res = alu_res;
            end
            rvstep_pkg::OPC_OP:
            begin
                ex_wr = 1'b1;
                if (f7 == rvstep_pkg::F7_MULDIV)
                begin
                    ex_ok   = 1'b1;
                    ex_kind = f3[2] ? rvstep_pkg::KIND_DIV : rvstep_pkg::KIND_MUL;
                end
                else
                begin
                    ex_ok  = alu_ok;
                    ex_res = alu_res;
                end
            end
            rvstep_pkg::OPC_AUIPC:
            begin
                ex_ok  = 1'b1;
                ex_wr  = 1'b1;
                ex_res = pc_byte + imm_u;
            end
            rvstep_pkg::OPC_LUI:
            begin
                ex_ok  = 1'b1;
                ex_wr  = 1'b1;
                ex_res = imm_u;
            end
            rvstep_pkg::OPC_STORE:
            begin
                ex_ok   = (f3 inside {3'd0, 3'd1, 3'd2});
                ex_kind = rvstep_pkg::KIND_STORE;
            end
            rvstep_pkg::OPC_BRANCH:
            begin
                ex_ok = !(f3 inside {3'd2, 3'd3});
                if (take)
                begin
                    ex_npc = br_sum[BYTE_W-1:2];
                end
            end
            rvstep_pkg::OPC_JAL:
            begin
                ex_ok  = 1'b1;
                ex_wr  = 1'b1;
                ex_res = link_v;
                ex_npc = jal_sum[BYTE_W-1:2];
            end
            rvstep_pkg::OPC_JALR:
            begin
                ex_ok  = (f3 == 3'd0);
                ex_wr  = 1'b1;
                ex_res = link_v;
                ex_npc = jalr_sum[BYTE_W-1:2];
            end
            rvstep_pkg::OPC_SYSTEM:
            begin
                ex_ok     = (f3 == 3'd0);
                ex_status = rvstep_pkg::HALT_ECALL;
            end
            default:
            begin
                ex_ok = 1'b0;
            end
        endcase
        if (!ex_ok)
        begin
            ex_wr     = 1'b0;
            ex_npc    = pc_reg;
            ex_status = rvstep_pkg::HALT_ILLEGAL;
            ex_kind   = rvstep_pkg::KIND_SIMPLE;
        end
    end

    // byte access sequencing
    assign baddr   = addr_reg + 32'(k_reg);
    assign n_m1    = (f3[1:0] == 2'd0) ? 2'd0 : ((f3[1:0] == 2'd1) ? 2'd1 : 2'd3);
    assign st_byte = rs2_q[{k_reg, 3'b000} +: 8];

    always_comb
    begin
        st_word = mem_q;
        st_word[{lane_reg, 3'b000} +: 8] = st_byte;
    end

    assign mem_we    = (in_fire && !command) || cmd.st_wr;
    assign mem_waddr = cmd.st_wr ? waddr_reg : ADDR_W'(load_address);
    assign mem_wdata = cmd.st_wr ? st_word : load_data;
    assign mem_re    = (in_fire && can_run) || cmd.mem_rd;
    assign mem_raddr = cmd.mem_rd ? baddr[BYTE_W-1:2] : pc_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    // register file, unwritten entries read as their reset value
    assign wr_eff = wr_reg && (rd != rvstep_pkg::REG_ZERO);

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_eff)
        begin
            rf[rd] <= res_reg;
        end
        if (cmd.latch_ins)
        begin
            rs1_q <= rf_vld_reg[mem_q[19:15]] ? rf[mem_q[19:15]]
                   : ((mem_q[19:15] == rvstep_pkg::REG_SP) ? STACK_TOP : 32'd0);
            rs2_q <= rf_vld_reg[mem_q[24:20]] ? rf[mem_q[24:20]]
                   : ((mem_q[24:20] == rvstep_pkg::REG_SP) ? STACK_TOP : 32'd0);
        end
    end

    // multiply and divide
    assign prod_c   = rs1_q * rs2_q;
    assign mul_hi   = prod_reg[63:32];
    assign corr_a   = rs1_q[31] ? rs2_q : 32'd0;
    assign corr_b   = rs2_q[31] ? rs1_q : 32'd0;
    assign a_neg    = !f3[0] && rs1_q[31];
    assign b_neg    = !f3[0] && rs2_q[31];
    assign mag_a    = a_neg ? (32'd0 - rs1_q) : rs1_q;
    assign mag_b    = b_neg ? (32'd0 - rs2_q) : rs2_q;
    assign div_rr   = {drem_reg, dquo_reg[31]};
    assign div_diff = div_rr - {1'b0, dvs_reg};
    assign quo_fix  = (a_neg ^ b_neg) ? (32'd0 - dquo_reg) : dquo_reg;
    assign rem_fix  = a_neg ? (32'd0 - drem_reg) : drem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_ins)
        begin
            ins_reg <= mem_q;
        end
        if (in_fire && !can_run)
        begin
            exw_reg <= '0;
            res_reg <= '0;
            npc_reg <= pc_reg;
            if (halt_reg != rvstep_pkg::HALT_NONE)
            begin
                st_reg <= halt_reg;
            end
            else
            begin
                st_reg <= command ? rvstep_pkg::HALT_PC_RANGE : rvstep_pkg::HALT_NONE;
            end
        end
        if (cmd.exec)
        begin
            exw_reg  <= ins_reg;
            res_reg  <= ex_res;
            npc_reg  <= ex_npc;
            st_reg   <= ex_status;
            addr_reg <= rs1_q + ((opc == rvstep_pkg::OPC_STORE) ? imm_s : imm_i);
            k_reg    <= 2'd0;
            acc_reg  <= '0;
            prod_reg <= prod_c;
            drem_reg <= '0;
            dquo_reg <= mag_a;
            dvs_reg  <= mag_b;
            dcnt_reg <= '0;
        end
        if (cmd.mul_fix)
        begin
            case (f3[1:0])
                2'd0:    res_reg <= prod_reg[31:0];
                2'd1:    res_reg <= mul_hi - corr_a - corr_b;
                2'd2:    res_reg <= mul_hi - corr_a;
                default: res_reg <= mul_hi;
            endcase
        end
        if (cmd.div_step)
        begin
            if (!div_diff[32])
            begin
                drem_reg <= div_diff[31:0];
                dquo_reg <= {dquo_reg[30:0], 1'b1};
            end
            else
            begin
                drem_reg <= div_rr[31:0];
                dquo_reg <= {dquo_reg[30:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 5'd1;
        end
        if (cmd.div_fix)
        begin
            if (rs2_q == 32'd0)
            begin
                res_reg <= f3[1] ? rs1_q : '1;
            end
            else
            begin
                res_reg <= f3[1] ? rem_fix : quo_fix;
            end
        end
        if (cmd.mem_rd)
        begin
            lane_reg  <= baddr[1:0];
            waddr_reg <= baddr[BYTE_W-1:2];
        end
        if (cmd.ld_cap)
        begin
            acc_reg[{k_reg, 3'b000} +: 8] <= mem_q[{lane_reg, 3'b000} +: 8];
            k_reg <= k_reg + 2'd1;
        end
        if (cmd.st_wr)
        begin
            k_reg <= k_reg + 2'd1;
        end
        if (cmd.ld_fix)
        begin
            case (f3)
                3'd0:    res_reg <= {{24{acc_reg[7]}}, acc_reg[7:0]};
                3'd1:    res_reg <= {{16{acc_reg[15]}}, acc_reg[15:0]};
                default: res_reg <= acc_reg;
            endcase
        end
        if (cmd.commit)
        begin
            out_exw_reg  <= exw_reg;
            out_npc_reg  <= rvstep_pkg::PC_OUT_W'(npc_reg);
            out_wr_reg   <= wr_eff;
            out_rd_reg   <= wr_eff ? rd : rvstep_pkg::REG_ZERO;
            out_val_reg  <= wr_eff ? res_reg : 32'd0;
            out_halt_reg <= st_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            halt_reg      <= rvstep_pkg::HALT_NONE;
            rf_vld_reg    <= '0;
            wr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire && !can_run)
            begin
                wr_reg <= 1'b0;
            end
            if (cmd.exec)
            begin
                wr_reg <= ex_wr;
            end
            if (cmd.commit)
            begin
                pc_reg <= npc_reg;
                if (st_reg != rvstep_pkg::HALT_NONE)
                begin
                    halt_reg <= st_reg;
                end
                if (wr_eff)
                begin
                    rf_vld_reg[rd] <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.in_valid  = in_valid;
    assign stat.can_run   = can_run;
    assign stat.last_byte = (k_reg == n_m1);
    assign stat.div_last  = (dcnt_reg == 5'd31);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.kind      = ex_kind;

    assign out_valid     = out_valid_reg;
    assign executed_word = out_exw_reg;
    assign next_pc       = out_npc_reg;
    assign reg_written   = out_wr_reg;
    assign dest_index    = out_rd_reg;
    assign dest_value    = out_val_reg;
    assign halt_status   = out_halt_reg;

endmodule

// File: sv/rv32im_instruction_step_unit.sv
// rv32im instruction step unit: top level with configuration register
// load command, or a step that executes nothing (halted or pc out of program): straight to finish
// step: alu, jump, branch, ecall, illegal: decode, exec, finish; multiply adds a fix-up;
// divide and remainder loop bit by bit, load and store one byte a pass
// one item at a time; the next item is taken once the result sits in the output register
// async active-low reset clears pc, halt, register file valid bits and program_words
module rv32im_instruction_step_unit #(
    parameter int MEM_WORDS = rvstep_pkg::MEM_WORDS_DEF,
    parameter int STACK_GAP = rvstep_pkg::STACK_GAP_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rvstep_in_if.sink                         req,
    rvstep_out_if.source                      rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rvstep_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [rvstep_pkg::PROG_WORDS_W-1:0] pw_reg;
    rvstep_pkg::ctrl_cmd_t               cmd;
    rvstep_pkg::dp_stat_t                stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[2] == rvstep_pkg::REG_PROGRAM_WORDS))
        begin
            pw_reg <= pwdata[rvstep_pkg::PROG_WORDS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == rvstep_pkg::REG_PROGRAM_WORDS) ? 32'(pw_reg) : 32'd0;

    assign req.ready = cmd.in_ready;

    rvstep_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .stat (stat),
        .cmd  (cmd)
    );

    rvstep_dp #(
        .MEM_WORDS(MEM_WORDS),
        .STACK_GAP(STACK_GAP)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_valid     (req.valid),
        .command      (req.command),
        .load_address (req.load_address),
        .load_data    (req.load_data),
        .program_words(pw_reg),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .executed_word(rsp.executed_word),
        .next_pc      (rsp.next_pc),
        .reg_written  (rsp.reg_written),
        .dest_index   (rsp.dest_index),
        .dest_value   (rsp.dest_value),
        .halt_status  (rsp.halt_status)
    );

endmodule

// File: sv/rvstep_checker.sv
// port-level checker of the rv32im instruction step unit and its bind
`include "rv32im_instruction_step_unit_macros.svh"

module rvstep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_reg_written,
    input logic [4:0]  rsp_dest_index,
    input logic [31:0] rsp_dest_value,
    input logic [1:0]  rsp_halt_status
);

    `RVSTEP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `RVSTEP_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)
    `RVSTEP_ASSERT_NOW(a_nowr_zero, rsp_valid && !rsp_reg_written, rsp_dest_index == 5'd0 && rsp_dest_value == 32'd0)
    `RVSTEP_ASSERT_NOW(a_no_x0, rsp_valid && rsp_reg_written, rsp_dest_index != 5'd0)
    `RVSTEP_ASSERT_NOW(a_illegal_nowr, rsp_valid && rsp_halt_status == rvstep_pkg::HALT_ILLEGAL, !rsp_reg_written)

endmodule

bind rv32im_instruction_step_unit rvstep_checker u_rvstep_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_reg_written(rsp.reg_written),
    .rsp_dest_index (rsp.dest_index),
    .rsp_dest_value (rsp.dest_value),
    .rsp_halt_status(rsp.halt_status)
);

// File: bench/tb_rv32im_instruction_step_unit.sv
// self-checking testbench for the rv32im instruction step unit
`timescale 1ns / 1ps

module tb_rv32im_instruction_step_unit;
    import rvstep_pkg::*;

    localparam int MEM_W       = MEM_WORDS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int STEPS_PHASE = 250;

    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_STEP = 1'b1;

    localparam logic [6:0] OPC_MISC_MEM = 7'h0f;

    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
    localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2, F3_MULHU = 3'd3;
    localparam logic [2:0] F3_DIV = 3'd4, F3_DIVU = 3'd5, F3_REM = 3'd6, F3_REMU = 3'd7;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2, F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_SB = 3'd0, F3_SH = 3'd1, F3_SW = 3'd2;
    localparam logic [2:0] F3_ECALL = 3'd0, F3_JALR = 3'd0;

    typedef struct {
        bit [31:0] word;
        bit [13:0] npc;
        bit        wr;
        bit [4:0]  rd;
        bit [31:0] val;
        halt_t     st;
    } step_report_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rvstep_in_if  req_if ();
    rvstep_out_if rsp_if ();

    rv32im_instruction_step_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bit [31:0]    arch_regs [NUM_REGS];
    bit [31:0]    arch_mem [MEM_W];
    bit           mem_written [MEM_W];
    bit [13:0]    arch_pc;
    bit           arch_halted;
    halt_t        arch_reason;
    bit [14:0]    arch_prog_words;
    step_report_t pending_reports[$];
    int           send_idle;
    int           recv_idle;
    int           fail_count;
    int           cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit [31:0] enc_r(bit [6:0] f7, bit [4:0] rs2, bit [4:0] rs1,
                                        bit [2:0] f3, bit [4:0] rd, bit [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic bit [31:0] enc_i(bit [11:0] imm, bit [4:0] rs1, bit [2:0] f3,
                                        bit [4:0] rd, bit [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic bit [31:0] enc_s(bit [11:0] imm, bit [4:0] rs2, bit [4:0] rs1,
                                        bit [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic bit [31:0] enc_b(bit [12:0] imm, bit [4:0] rs2, bit [4:0] rs1,
                                        bit [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic bit [31:0] enc_j(bit [20:0] imm, bit [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    function automatic bit [31:0] read_bytes(bit [31:0] addr, int n);
        bit [31:0] v;
        bit [15:0] b;
        v = 0;
        for (int k = 0; k < n; k++)
        begin
            b = 16'(addr + k);
            v |= ((arch_mem[b[15:2]] >> (8 * b[1:0])) & 32'hff) << (8 * k);
        end
        return v;
    endfunction

    function automatic void write_bytes(bit [31:0] addr, bit [31:0] data, int n);
        bit [15:0] b;
        for (int k = 0; k < n; k++)
        begin
            b = 16'(addr + k);
            arch_mem[b[15:2]] = (arch_mem[b[15:2]] & ~(32'hff << (8 * b[1:0])))
                              | (((data >> (8 * k)) & 32'hff) << (8 * b[1:0]));
        end
    endfunction

    function automatic bit alu_op(bit [2:0] f3, bit [6:0] f7, bit [31:0] a, bit [31:0] b,
                                  bit reg_op, output bit [31:0] r);
        bit [4:0]         s;
        bit [63:0]        p;
        bit               ovf;
        bit signed [31:0] sq;
        bit signed [31:0] sr;
        s = b[4:0];
        r = 0;
        ovf = (a == 32'h80000000) && (b == 32'hffffffff);
        sq = (b == 0 || ovf) ? 32'sd0 : $signed(a) / $signed(b);
        sr = (b == 0 || ovf) ? 32'sd0 : $signed(a) % $signed(b);
        if (reg_op && f7 == F7_MULDIV)
        begin
            case (f3)
                F3_MUL:    r = a * b;
                F3_MULH:
                begin
                    p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                    r = p[63:32];
                end
                F3_MULHSU:
                begin
                    p = {{32{a[31]}}, a} * {32'b0, b};
                    r = p[63:32];
                end
                F3_MULHU:
                begin
                    p = {32'b0, a} * {32'b0, b};
                    r = p[63:32];
                end
                F3_DIV:    r = (b == 0) ? 32'hffffffff : ovf ? a : sq;
                F3_DIVU:   r = (b == 0) ? 32'hffffffff : a / b;
                F3_REM:    r = (b == 0) ? a : ovf ? 32'd0 : sr;
                default:   r = (b == 0) ? a : a % b;
            endcase
            return 1'b1;
        end
        if (reg_op && f7 != F7_BASE && !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))
            return 1'b0;
        if (!reg_op && f3 == F3_SLL && f7 != F7_BASE)
            return 1'b0;
        if (!reg_op && f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)
            return 1'b0;
        case (f3)
            F3_ADD:  r = (reg_op && f7 == F7_ALT) ? a - b : a + b;
            F3_SLL:  r = a << s;
            F3_SLT:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: r = (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  r = a ^ b;
            F3_SR:   r = (f7 == F7_ALT) ? $unsigned($signed(a) >>> s) : a >> s;
            F3_OR:   r = a | b;
            default: r = a & b;
        endcase
        return 1'b1;
    endfunction

    // executes one instruction word on the architectural state
    function automatic step_report_t execute_word(bit [31:0] ins);
        step_report_t r;
        bit [4:0]  rd;
        bit [2:0]  f3;
        bit [6:0]  f7;
        bit [31:0] a, b, imm, val, tmp, link;
        bit [15:0] tgt;
        bit [13:0] npc;
        bit        wr, ok, take;
        halt_t     st;
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        a = arch_regs[ins[19:15]];
        b = arch_regs[ins[24:20]];
        imm = {{20{ins[31]}}, ins[31:20]};
        link = (32'(arch_pc) + 32'd1) << 2;
        val = 0;
        wr = 1'b0;
        ok = 1'b1;
        take = 1'b0;
        st = HALT_NONE;
        npc = arch_pc + 14'd1;
        case (ins[6:0])
            OPC_LOAD:
            begin
                tmp = read_bytes(a + imm, 4);
                case (f3)
                    F3_LB:   val = {{24{tmp[7]}}, tmp[7:0]};
                    F3_LH:   val = {{16{tmp[15]}}, tmp[15:0]};
                    F3_LW:   val = tmp;
                    F3_LBU:  val = {24'b0, tmp[7:0]};
                    F3_LHU:  val = {16'b0, tmp[15:0]};
                    default: ok = 1'b0;
                endcase
                wr = ok;
            end
            OPC_OPIMM:
            begin
                ok = alu_op(f3, f7, a, imm, 1'b0, val);
                wr = ok;
            end
            OPC_OP:
            begin
                ok = alu_op(f3, f7, a, b, 1'b1, val);
                wr = ok;
            end
            OPC_AUIPC:
            begin
                val = (32'(arch_pc) << 2) + (ins & UPPER_MASK);
                wr = 1'b1;
            end
            OPC_LUI:
            begin
                val = ins & UPPER_MASK;
                wr = 1'b1;
            end
            OPC_STORE:
            begin
                imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
                if (f3 <= F3_SW)
                    write_bytes(a + imm, b, 1 << f3);
                else
                    ok = 1'b0;
            end
            OPC_BRANCH:
            begin
                imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = ($signed(a) < $signed(b));
                    F3_BGE:  take = ($signed(a) >= $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: ok = 1'b0;
                endcase
                if (take)
                begin
                    tgt = {arch_pc, 2'b00} + imm[15:0];
                    npc = tgt[15:2];
                end
            end
            OPC_JAL:
            begin
                imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                val = link;
                wr = 1'b1;
                tgt = {arch_pc, 2'b00} + imm[15:0];
                npc = tgt[15:2];
            end
            OPC_JALR:
            begin
                if (f3 != F3_JALR)
                    ok = 1'b0;
                else
                begin
                    val = link;
                    wr = 1'b1;
                    tgt = 16'(a + imm);
                    npc = tgt[15:2];
                end
            end
            OPC_SYSTEM:
            begin
                if (f3 == F3_ECALL)
                    st = HALT_ECALL;
                else
                    ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase
        if (!ok)
        begin
            wr = 1'b0;
            npc = arch_pc;
            st = HALT_ILLEGAL;
        end
        if (wr && rd != REG_ZERO)
            arch_regs[rd] = val;
        else
            wr = 1'b0;
        if (!wr)
        begin
            rd = 0;
            val = 0;
        end
        arch_pc = npc;
        if (st != HALT_NONE)
        begin
            arch_halted = 1'b1;
            arch_reason = st;
        end
        r.word = ins;
        r.npc = npc;
        r.wr = wr;
        r.rd = rd;
        r.val = val;
        r.st = st;
        return r;
    endfunction

    function automatic step_report_t predict_item(bit cmd, bit [13:0] addr, bit [31:0] data);
        step_report_t r;
        r.word = 0;
        r.wr = 1'b0;
        r.rd = 0;
        r.val = 0;
        if (cmd == CMD_LOAD)
        begin
            arch_mem[addr] = data;
            mem_written[addr] = 1'b1;
            r.st = arch_halted ? arch_reason : HALT_NONE;
        end
        else if (arch_halted)
            r.st = arch_reason;
        else if (15'(arch_pc) >= arch_prog_words)
        begin
            arch_halted = 1'b1;
            arch_reason = HALT_PC_RANGE;
            r.st = HALT_PC_RANGE;
        end
        else
            return execute_word(arch_mem[arch_pc]);
        r.npc = arch_pc;
        return r;
    endfunction

    always @(posedge clk)
    begin
        step_report_t e;
        rsp_if.ready <= ($urandom_range(99) >= recv_idle);
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%t unexpected result item, word %h", $time, rsp_if.executed_word);
                fail_count++;
            end
            else
            begin
                e = pending_reports.pop_front();
                if (rsp_if.executed_word !== e.word || rsp_if.next_pc !== e.npc
                    || rsp_if.reg_written !== e.wr || rsp_if.dest_index !== e.rd
                    || rsp_if.dest_value !== e.val || rsp_if.halt_status !== e.st)
                begin
                    $display("%t mismatch exp word %h pc %0d wr %b rd %0d val %h st %0d",
                             $time, e.word, e.npc, e.wr, e.rd, e.val, e.st);
                    $display("%t          act word %h pc %0d wr %b rd %0d val %h st %0d",
                             $time, rsp_if.executed_word, rsp_if.next_pc, rsp_if.reg_written,
                             rsp_if.dest_index, rsp_if.dest_value, rsp_if.halt_status);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(bit cmd, bit [13:0] addr, bit [31:0] data);
        pending_reports.push_back(predict_item(cmd, addr, data));
        if ($urandom_range(99) < send_idle)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.command <= cmd;
        req_if.load_address <= addr;
        req_if.load_data <= data;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_program_words(bit [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_PROGRAM_WORDS, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        arch_prog_words = value[14:0];
        @(posedge clk);
    endtask

    // fills any unwritten data word the access touches, places the word at pc, steps
    task automatic run_instruction(bit [31:0] ins);
        bit [31:0] imm, addr;
        bit [2:0]  f3;
        bit [15:0] b;
        int        n;
        f3 = ins[14:12];
        n = 0;
        imm = {{20{ins[31]}}, ins[31:20]};
        if (ins[6:0] == OPC_LOAD)
            n = (f3 == F3_LW) ? 4 : (f3 == F3_LH || f3 == F3_LHU) ? 2 :
                (f3 == F3_LB || f3 == F3_LBU) ? 1 : 0;
        if (ins[6:0] == OPC_STORE && f3 <= F3_SW)
        begin
            imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            n = 1 << f3;
        end
        addr = arch_regs[ins[19:15]] + imm;
        for (int k = 0; k < n; k++)
        begin
            b = 16'(addr + k);
            if (!mem_written[b[15:2]])
                send_item(CMD_LOAD, b[15:2], $urandom);
        end
        send_item(CMD_LOAD, arch_pc, ins);
        send_item(CMD_STEP, 14'($urandom), $urandom);
    endtask

    function automatic bit [31:0] random_instruction();
        bit [4:0]  rd, rs1, rs2;
        bit [2:0]  f3;
        bit [6:0]  f7;
        bit [11:0] imm;
        bit [2:0]  load_f3 [5];
        bit [2:0]  br_f3 [6];
        load_f3 = '{F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};
        br_f3 = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
        rd = 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        f3 = 3'($urandom);
        imm = 12'($urandom);
        case ($urandom_range(8))
            0:
            begin
                case ($urandom_range(2))
                    0:       f7 = F7_BASE;
                    1:       f7 = F7_MULDIV;
                    default: f7 = (f3 == F3_ADD || f3 == F3_SR) ? F7_ALT : F7_BASE;
                endcase
                if ($urandom_range(7) == 0)
                    rs2 = REG_ZERO;
                return enc_r(f7, rs2, rs1, f3, rd, OPC_OP);
            end
            1:
            begin
                if (f3 == F3_SLL)
                    imm[11:5] = F7_BASE;
                if (f3 == F3_SR)
                    imm[11:5] = $urandom_range(1) ? F7_ALT : F7_BASE;
                return enc_i(imm, rs1, f3, rd, OPC_OPIMM);
            end
            2:       return {$urandom} & UPPER_MASK | {20'b0, rd, OPC_LUI};
            3:       return {$urandom} & UPPER_MASK | {20'b0, rd, OPC_AUIPC};
            4:       return enc_i(imm, rs1, load_f3[$urandom_range(4)], rd, OPC_LOAD);
            5:       return enc_s(imm, rs2, rs1, 3'($urandom_range(F3_SW)));
            6:       return enc_b(13'($urandom), rs2, rs1, br_f3[$urandom_range(5)]);
            7:       return enc_j(21'($urandom), rd);
            default: return enc_i(imm, rs1, F3_JALR, rd, OPC_JALR);
        endcase
    endfunction

    // picks an instruction whose next pc stays inside the program
    task automatic next_instruction(output bit [31:0] ins);
        bit [31:0]    saved_regs [NUM_REGS];
        bit [13:0]    saved_pc;
        step_report_t r;
        bit           ok;
        ok = 1'b0;
        for (int tries = 0; tries < 100 && !ok; tries++)
        begin
            ins = random_instruction();
            if (ins[6:0] == OPC_STORE)
                ok = 15'(arch_pc + 14'd1) < arch_prog_words;
            else
            begin
                saved_regs = arch_regs;
                saved_pc = arch_pc;
                r = execute_word(ins);
                ok = 15'(r.npc) < arch_prog_words;
                arch_regs = saved_regs;
                arch_pc = saved_pc;
            end
        end
        if (!ok)
            ins = enc_j(21'(-(32'(arch_pc) << 2)), REG_ZERO);
    endtask

    task automatic test_reset_loads();
        send_idle = 15;
        recv_idle = 52;
        write_program_words(0);
        send_item(CMD_LOAD, 14'h0000, 32'h00000000);
        send_item(CMD_LOAD, 14'h3fff, 32'hffffffff);
        send_item(CMD_LOAD, 14'h2aaa, 32'ha5a5a5a5);
        wait_idle();
    endtask

    task automatic test_directed();
        write_program_words(MEM_W);
        run_instruction(enc_i(12'hfff, REG_ZERO, F3_ADD, 5'd1, OPC_OPIMM));
        run_instruction({20'h80000, 5'd3, OPC_LUI});
        run_instruction(enc_r(F7_MULDIV, 5'd1, 5'd3, F3_DIV, 5'd4, OPC_OP));
        run_instruction(enc_r(F7_MULDIV, 5'd1, 5'd3, F3_REM, 5'd5, OPC_OP));
        run_instruction(enc_r(F7_MULDIV, REG_ZERO, 5'd1, F3_DIVU, 5'd6, OPC_OP));
        run_instruction(enc_r(F7_MULDIV, REG_ZERO, 5'd1, F3_REMU, 5'd7, OPC_OP));
        run_instruction(enc_r(F7_MULDIV, 5'd3, 5'd3, F3_MULH, 5'd8, OPC_OP));
        run_instruction(enc_r(F7_ALT, 5'd1, 5'd3, F3_SR, 5'd9, OPC_OP));
        run_instruction(enc_i(12'hfff, REG_ZERO, F3_SLTU, 5'd10, OPC_OPIMM));
        run_instruction(enc_s(12'd2, 5'd1, REG_SP, F3_SW));
        run_instruction(enc_i(12'hfff, REG_ZERO, F3_LHU, 5'd11, OPC_LOAD));
        run_instruction(enc_i(12'hfff, REG_ZERO, F3_JALR, 5'd12, OPC_JALR));
        run_instruction(enc_i(12'd1, 5'd1, F3_ADD, REG_ZERO, OPC_OPIMM));
        run_instruction(enc_j(21'h1ff800, 5'd1));
        wait_idle();
    endtask

    task automatic test_random(int s_idle, int r_idle, bit [31:0] prog_words);
        bit [31:0] ins;
        send_idle = s_idle;
        recv_idle = r_idle;
        write_program_words(prog_words);
        for (int i = 0; i < STEPS_PHASE; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(CMD_LOAD, 14'($urandom), $urandom);
            else
            begin
                next_instruction(ins);
                run_instruction(ins);
            end
        end
        wait_idle();
    endtask

    task automatic test_halt();
        bit [2:0] bad_f3 [3];
        bad_f3 = '{3'd3, 3'd6, 3'd7};
        case ($urandom_range(2))
            0:
                run_instruction({$urandom} & 32'hffff8f80 | {25'b0, OPC_SYSTEM});
            1:
                case ($urandom_range(4))
                    0: run_instruction({$urandom} & 32'hffffff80 | {25'b0, OPC_MISC_MEM});
                    1: run_instruction(enc_i({7'($urandom_range(1, 127)), 5'($urandom)},
                                             5'($urandom), F3_SLL, 5'($urandom), OPC_OPIMM));
                    2: run_instruction(enc_i(12'($urandom), 5'($urandom),
                                             3'($urandom_range(1, 7)), 5'($urandom), OPC_JALR));
                    3: run_instruction(enc_i(12'($urandom), 5'($urandom),
                                             bad_f3[$urandom_range(2)], 5'($urandom), OPC_LOAD));
                    default: run_instruction(enc_r(7'h02, 5'($urandom), 5'($urandom),
                                                   3'($urandom), 5'($urandom), OPC_OP));
                endcase
            default:
            begin
                write_program_words(32'(arch_pc));
                send_item(CMD_STEP, 14'($urandom), $urandom);
            end
        endcase
        for (int i = 0; i < 6; i++)
            send_item(1'($urandom), 14'($urandom), $urandom);
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.command = CMD_LOAD;
        req_if.load_address = '0;
        req_if.load_data = '0;
        rsp_if.ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        send_idle = 0;
        recv_idle = 0;
        for (int i = 0; i < NUM_REGS; i++)
            arch_regs[i] = 0;
        arch_regs[REG_SP] = 32'(4 * MEM_W - STACK_GAP_DEF);
        arch_pc = 0;
        arch_halted = 1'b0;
        arch_reason = HALT_NONE;
        arch_prog_words = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_loads();
        test_directed();
        test_random(15, 52, MEM_W);
        test_random(52, 15, $urandom_range(32'(arch_pc) + 1, MEM_W));
        test_random(0, 0, $urandom_range(32'(arch_pc) + 1, MEM_W));
        test_halt();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
